>>> design/io_request_sorted_dispatcher_unit_macros.svh
// ----------------------------------------------------------------------------
// io request sorted dispatcher assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IO_REQUEST_SORTED_DISPATCHER_UNIT_MACROS_SVH
`define IO_REQUEST_SORTED_DISPATCHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define IOSD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("iosd check failed");
`define IOSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iosd check failed");
`else
`define IOSD_ASSERT_ALWAYS(label, expr)
`define IOSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/iosd_pkg.sv
// ----------------------------------------------------------------------------
// iosd_pkg
// shared types and constants of the sector sorted request dispatcher
// ----------------------------------------------------------------------------
package iosd_pkg;

  localparam int HEAD_DEPTH_DEF   = 16;
  localparam int SORTED_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF     = 16;
  localparam int SECTOR_BITS      = 48;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

>>> design/iosd_in_if.sv
// ----------------------------------------------------------------------------
// iosd_in_if
// request channel: insert or dispatch command words
// ----------------------------------------------------------------------------
interface iosd_in_if #(
  parameter int TAG_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic                    at_head;
  logic                    is_write;
  logic [47:0]             start_sector;
  logic [TAG_BITS-1:0]     request_tag;

  modport source (output valid, command, at_head, is_write, start_sector, request_tag,
                  input ready);
  modport sink   (input valid, command, at_head, is_write, start_sector, request_tag,
                  output ready);
endinterface

>>> design/iosd_out_if.sv
// ----------------------------------------------------------------------------
// iosd_out_if
// result channel: one word per accepted command
// ----------------------------------------------------------------------------
interface iosd_out_if #(
  parameter int TAG_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [TAG_BITS-1:0]     out_tag;
  logic [47:0]             out_sector;
  logic                    out_write;
  logic                    pending;

  modport source (output valid, status, out_tag, out_sector, out_write, pending,
                  input ready);
  modport sink   (input valid, status, out_tag, out_sector, out_write, pending,
                  output ready);
endinterface

>>> design/io_request_sorted_dispatcher_unit.sv
// an accepted request word passes the exec state, then its result word is presented in the response state
// the idle-exec-response sequencer takes no new word until the last result word is taken
// an insert shifts the whole sorted cell row at once, so depth does not lengthen an insert
// reset: synchronous active low, clears fifo pointers, counts and sequencer state
// stores and fifo contents stay undefined, no clearing pass after reset
// ----------------------------------------------------------------------------
// io_request_sorted_dispatcher_unit
// head fifo plus sector sorted read and write queues with priority dispatch
// ----------------------------------------------------------------------------
`include "io_request_sorted_dispatcher_unit_macros.svh"

module io_request_sorted_dispatcher_unit #(
  parameter int HEAD_DEPTH   = iosd_pkg::HEAD_DEPTH_DEF,
  parameter int SORTED_DEPTH = iosd_pkg::SORTED_DEPTH_DEF,
  parameter int TAG_BITS     = iosd_pkg::TAG_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  iosd_in_if.sink    in_req,
  iosd_out_if.source out_rsp
);
  import iosd_pkg::*;

  dp_cmd_t cmd;

  iosd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  iosd_datapath #(
    .HEAD_DEPTH   (HEAD_DEPTH),
    .SORTED_DEPTH (SORTED_DEPTH),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_command  (in_req.command),
    .in_at_head  (in_req.at_head),
    .in_is_write (in_req.is_write),
    .in_sector   (in_req.start_sector),
    .in_tag      (in_req.request_tag),
    .out_status  (out_rsp.status),
    .out_tag     (out_rsp.out_tag),
    .out_sector  (out_rsp.out_sector),
    .out_write   (out_rsp.out_write),
    .out_pending (out_rsp.pending)
  );

  `IOSD_ASSERT_ALWAYS(a_no_overlap, !(in_req.ready && out_rsp.valid))
  `IOSD_ASSERT_NEXT(a_accept_exec, in_req.valid && in_req.ready, cmd.exec)
  `IOSD_ASSERT_NEXT(a_exec_resp, cmd.exec, out_rsp.valid)

endmodule

>>> design/iosd_sorted_store.sv
// ----------------------------------------------------------------------------
// iosd_sorted_store
// row of cells kept sorted by sector, insert and pop each shift the whole row at once
// ----------------------------------------------------------------------------
module iosd_sorted_store #(
  parameter int SORTED_DEPTH = 32,
  parameter int TAG_BITS     = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ins_en,
  input  logic                                  pop_en,
  input  logic [iosd_pkg::SECTOR_BITS-1:0]      key,
  input  logic [TAG_BITS-1:0]                   tag_in,
  output logic [$clog2(SORTED_DEPTH+1)-1:0]     count,
  output logic [iosd_pkg::SECTOR_BITS-1:0]      front_sector,
  output logic [TAG_BITS-1:0]                   front_tag
);
  import iosd_pkg::*;

  localparam int CW = $clog2(SORTED_DEPTH + 1);

  logic [SECTOR_BITS-1:0] sec_r [SORTED_DEPTH];
  logic [TAG_BITS-1:0]    tag_r [SORTED_DEPTH];
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_nxt;
  logic [SORTED_DEPTH-1:0] gt;

  // unused cells count as greater so the new word lands right after the last one
  always_comb begin
    for (int i = 0; i < SORTED_DEPTH; i++) begin
      gt[i] = (CW'(i) < cnt_r) ? (sec_r[i] > key) : 1'b1;
    end
  end

  for (genvar i = 0; i < SORTED_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ins_en && gt[i]) begin
        if (i == 0) begin
          sec_r[i] <= key;
          tag_r[i] <= tag_in;
        end else if (!gt[(i == 0) ? 0 : i-1]) begin
          sec_r[i] <= key;
          tag_r[i] <= tag_in;
        end else begin
          sec_r[i] <= sec_r[(i == 0) ? 0 : i-1];
          tag_r[i] <= tag_r[(i == 0) ? 0 : i-1];
        end
      end else if (pop_en && (i < SORTED_DEPTH-1)) begin
        sec_r[i] <= sec_r[(i < SORTED_DEPTH-1) ? i+1 : i];
        tag_r[i] <= tag_r[(i < SORTED_DEPTH-1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign count        = cnt_r;
  assign front_sector = sec_r[0];
  assign front_tag    = tag_r[0];

endmodule

>>> design/iosd_datapath.sv
// ----------------------------------------------------------------------------
// iosd_datapath
// head fifo, read and write sorted stores and the result register
// ----------------------------------------------------------------------------
module iosd_datapath #(
  parameter int HEAD_DEPTH   = 16,
  parameter int SORTED_DEPTH = 32,
  parameter int TAG_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iosd_pkg::dp_cmd_t                 cmd,
  input  logic                              in_command,
  input  logic                              in_at_head,
  input  logic                              in_is_write,
  input  logic [iosd_pkg::SECTOR_BITS-1:0]  in_sector,
  input  logic [TAG_BITS-1:0]               in_tag,
  output logic [1:0]                        out_status,
  output logic [TAG_BITS-1:0]               out_tag,
  output logic [iosd_pkg::SECTOR_BITS-1:0]  out_sector,
  output logic                              out_write,
  output logic                              out_pending
);
  import iosd_pkg::*;

  localparam int PW  = $clog2(HEAD_DEPTH);
  localparam int HCW = $clog2(HEAD_DEPTH + 1);
  localparam int SCW = $clog2(SORTED_DEPTH + 1);

  logic                   command_r, at_head_r, is_write_r;
  logic [SECTOR_BITS-1:0] sector_r;
  logic [TAG_BITS-1:0]    tag_r;

  logic [TAG_BITS-1:0]    head_mem [HEAD_DEPTH];
  logic [TAG_BITS-1:0]    head_rd_r;
  logic [PW-1:0]          rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [HCW-1:0]         hcnt_r, hcnt_nxt;

  logic [SCW-1:0]         rd_cnt, wr_cnt;
  logic [SECTOR_BITS-1:0] rd_front_sec, wr_front_sec;
  logic [TAG_BITS-1:0]    rd_front_tag, wr_front_tag;

  logic is_ins, head_full, rd_full, wr_full, ins_full, nothing;
  logic head_push, head_pop, rd_ins, wr_ins, rd_pop, wr_pop;

  logic [1:0]             status_r;
  logic                   from_head_r, write_o_r;
  logic [TAG_BITS-1:0]    tag_o_r;
  logic [SECTOR_BITS-1:0] sector_o_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_r  <= in_command;
      at_head_r  <= in_at_head;
      is_write_r <= in_is_write;
      sector_r   <= in_sector;
      tag_r      <= in_tag;
    end
  end

  assign is_ins    = !command_r;
  assign head_full = (hcnt_r == HCW'(HEAD_DEPTH));
  assign rd_full   = (rd_cnt == SCW'(SORTED_DEPTH));
  assign wr_full   = (wr_cnt == SCW'(SORTED_DEPTH));
  assign ins_full  = at_head_r ? head_full : (is_write_r ? wr_full : rd_full);
  assign nothing   = (hcnt_r == '0) && (rd_cnt == '0) && (wr_cnt == '0);

  assign head_push = cmd.exec && is_ins && at_head_r && !head_full;
  assign rd_ins    = cmd.exec && is_ins && !at_head_r && !is_write_r && !rd_full;
  assign wr_ins    = cmd.exec && is_ins && !at_head_r && is_write_r && !wr_full;
  // dispatch priority: head fifo, then reads, then writes
  assign head_pop  = cmd.exec && !is_ins && (hcnt_r != '0);
  assign rd_pop    = cmd.exec && !is_ins && (hcnt_r == '0) && (rd_cnt != '0);
  assign wr_pop    = cmd.exec && !is_ins && (hcnt_r == '0) && (rd_cnt == '0)
                     && (wr_cnt != '0);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    hcnt_nxt   = hcnt_r;
    if (head_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(HEAD_DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      hcnt_nxt   = hcnt_r + HCW'(1);
    end
    if (head_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(HEAD_DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      hcnt_nxt   = hcnt_r - HCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      hcnt_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      hcnt_r   <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (head_push) begin
      head_mem[wr_ptr_r] <= tag_r;
    end
    if (cmd.exec) begin
      head_rd_r <= head_mem[rd_ptr_r];
    end
  end

  iosd_sorted_store #(
    .SORTED_DEPTH (SORTED_DEPTH),
    .TAG_BITS     (TAG_BITS)
  ) u_rd_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .ins_en       (rd_ins),
    .pop_en       (rd_pop),
    .key          (sector_r),
    .tag_in       (tag_r),
    .count        (rd_cnt),
    .front_sector (rd_front_sec),
    .front_tag    (rd_front_tag)
  );

  iosd_sorted_store #(
    .SORTED_DEPTH (SORTED_DEPTH),
    .TAG_BITS     (TAG_BITS)
  ) u_wr_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .ins_en       (wr_ins),
    .pop_en       (wr_pop),
    .key          (sector_r),
    .tag_in       (tag_r),
    .count        (wr_cnt),
    .front_sector (wr_front_sec),
    .front_tag    (wr_front_tag)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_ins) begin
        status_r <= ins_full ? ST_FULL : ST_OK;
      end else begin
        status_r <= nothing ? ST_EMPTY : ST_OK;
      end
      from_head_r <= head_pop;
      write_o_r   <= wr_pop;
      tag_o_r     <= rd_pop ? rd_front_tag : (wr_pop ? wr_front_tag : '0);
      sector_o_r  <= rd_pop ? rd_front_sec : (wr_pop ? wr_front_sec : '0);
    end
  end

  // head fifo tag comes out of the memory read register
  assign out_status  = status_r;
  assign out_tag     = from_head_r ? head_rd_r : tag_o_r;
  assign out_sector  = sector_o_r;
  assign out_write   = write_o_r;
  assign out_pending = (hcnt_r != '0) || (rd_cnt != '0) || (wr_cnt != '0);

endmodule

>>> design/iosd_ctrl.sv
// ----------------------------------------------------------------------------
// iosd_ctrl
// sequencer: take a word, run it through the datapath, hold the result
// ----------------------------------------------------------------------------
module iosd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output iosd_pkg::dp_cmd_t cmd
);
  import iosd_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_RESP;
      S_RESP:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC:  cmd.exec  = 1'b1;
      S_RESP:  out_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

endmodule

>>> test/io_request_sorted_dispatcher_unit_tb.sv
// ----------------------------------------------------------------------------
// io_request_sorted_dispatcher_unit_tb
// drives insert and dispatch words into the dispatcher, keeps its own model of
// the head fifo and the sorted read and write queues, checks every result word
// ----------------------------------------------------------------------------
module io_request_sorted_dispatcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iosd_pkg::*;

  localparam int HEAD_DEPTH   = 16;
  localparam int SORTED_DEPTH = 32;
  localparam int TAG_BITS     = 16;
  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;
  localparam logic [47:0] SECTOR_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0]         sector;
    logic [TAG_BITS-1:0] tag;
  } queued_req_t;

  typedef struct {
    logic [1:0]          status;
    logic [TAG_BITS-1:0] tag;
    logic [47:0]         sector;
    logic                wr;
    logic                pending;
  } dispatch_result_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  bit   hold_off;

  iosd_in_if  #(.TAG_BITS(TAG_BITS)) in_req ();
  iosd_out_if #(.TAG_BITS(TAG_BITS)) out_rsp ();

  io_request_sorted_dispatcher_unit #(
    .HEAD_DEPTH(HEAD_DEPTH), .SORTED_DEPTH(SORTED_DEPTH), .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  // scheduler state as predicted
  logic [TAG_BITS-1:0] head_tags[$];
  queued_req_t         read_queue[$];
  queued_req_t         write_queue[$];
  dispatch_result_t    expected_results[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // insert after every entry whose sector is not greater
  function automatic void sorted_add(ref queued_req_t q[$], input queued_req_t e);
    int pos;
    pos = 0;
    while (pos < q.size() && q[pos].sector <= e.sector) pos++;
    q.insert(pos, e);
  endfunction

  function automatic dispatch_result_t predict_step(logic cmd, logic head, logic wr,
                                                    logic [47:0] sec,
                                                    logic [TAG_BITS-1:0] tag);
    dispatch_result_t r;
    queued_req_t e;
    r = '{ST_OK, '0, '0, 1'b0, 1'b0};
    e.sector = sec;
    e.tag    = tag;
    if (cmd == CMD_INSERT) begin
      if (head) begin
        if (head_tags.size() >= HEAD_DEPTH) r.status = ST_FULL;
        else head_tags.push_back(tag);
      end else if (wr) begin
        if (write_queue.size() >= SORTED_DEPTH) r.status = ST_FULL;
        else sorted_add(write_queue, e);
      end else begin
        if (read_queue.size() >= SORTED_DEPTH) r.status = ST_FULL;
        else sorted_add(read_queue, e);
      end
    end else begin
      if (head_tags.size() != 0) begin
        r.tag = head_tags.pop_front();
      end else if (read_queue.size() != 0) begin
        e = read_queue.pop_front();
        r.tag = e.tag;
        r.sector = e.sector;
      end else if (write_queue.size() != 0) begin
        e = write_queue.pop_front();
        r.tag = e.tag;
        r.sector = e.sector;
        r.wr = 1'b1;
      end else begin
        r.status = ST_EMPTY;
      end
    end
    r.pending = (head_tags.size() + read_queue.size() + write_queue.size()) != 0;
    return r;
  endfunction

  // valid is already low here, so the wait before driving always ends on a falling edge
  task automatic send_word(logic cmd, logic head, logic wr, logic [47:0] sec,
                           logic [TAG_BITS-1:0] tag);
    int gap;
    gap = short_gap();
    repeat (gap + 1) @(negedge clk);
    in_req.valid        <= 1'b1;
    in_req.command      <= cmd;
    in_req.at_head      <= head;
    in_req.is_write     <= wr;
    in_req.start_sector <= sec;
    in_req.request_tag  <= tag;
    do @(posedge clk); while (!in_req.ready);
    expected_results.push_back(predict_step(cmd, head, wr, sec, tag));
    @(negedge clk);
    in_req.valid <= 1'b0;
  endtask

  task automatic offer_insert(logic head, logic wr, logic [47:0] sec,
                              logic [TAG_BITS-1:0] tag);
    send_word(CMD_INSERT, head, wr, sec, tag);
  endtask

  task automatic offer_dispatch();
    send_word(CMD_DISPATCH, 1'($urandom), 1'($urandom), 48'({$urandom, $urandom}),
              TAG_BITS'($urandom));
  endtask

  task automatic drain_all();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // result checker
  initial begin
    dispatch_result_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_rsp.valid && out_rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result word status %0d", $time, out_rsp.status);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_rsp.status !== e.status || out_rsp.out_tag !== e.tag ||
              out_rsp.out_sector !== e.sector || out_rsp.out_write !== e.wr ||
              out_rsp.pending !== e.pending) begin
            $display("%0t mismatch exp st=%0d tag=%h sec=%h wr=%b pend=%b", $time,
                     e.status, e.tag, e.sector, e.wr, e.pending);
            $display("%0t          got st=%0d tag=%h sec=%h wr=%b pend=%b", $time,
                     out_rsp.status, out_rsp.out_tag, out_rsp.out_sector,
                     out_rsp.out_write, out_rsp.pending);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    out_rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_rsp.ready <= 1'b0;
      end else begin
        gap = short_gap();
        if (gap == 0) begin
          out_rsp.ready <= 1'b1;
        end else begin
          out_rsp.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic test_extremes();
    offer_dispatch();
    offer_insert(1'b0, 1'b0, SECTOR_MAX, 16'hFFFF);
    offer_insert(1'b0, 1'b0, '0, 16'h0000);
    offer_insert(1'b0, 1'b1, SECTOR_MAX, 16'h5A5A);
    offer_insert(1'b0, 1'b1, 48'h0000_0000_0001, 16'hA5A5);
    offer_insert(1'b1, 1'b0, SECTOR_MAX, 16'h1234);
    offer_insert(1'b1, 1'b1, 48'hAAAA_AAAA_AAAA, 16'hFFFF);
    offer_insert(1'b0, 1'b0, 48'h5555_5555_5555, 16'h0001);
    offer_insert(1'b0, 1'b0, 48'h5555_5555_5555, 16'h0002);
    repeat (9) offer_dispatch();
    drain_all();
  endtask

  task automatic test_full_stores();
    for (int i = 0; i < HEAD_DEPTH + 1; i++) begin
      offer_insert(1'b1, i[0], 48'(i), TAG_BITS'(i));
    end
    for (int i = 0; i < SORTED_DEPTH + 1; i++) begin
      offer_insert(1'b0, 1'b0, 48'($urandom_range(0, 9)), TAG_BITS'(i));
    end
    for (int i = 0; i < SORTED_DEPTH + 1; i++) begin
      offer_insert(1'b0, 1'b1, 48'($urandom_range(0, 9)), TAG_BITS'(i));
    end
    repeat (HEAD_DEPTH + 2 * SORTED_DEPTH + 2) offer_dispatch();
    drain_all();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (300) @(negedge clk);
      repeat (40) offer_insert(1'($urandom), 1'($urandom), 48'($urandom_range(0, 50)),
                               TAG_BITS'($urandom));
    join_any
    hold_off = 1'b0;
    wait fork;
    repeat (40) offer_dispatch();
    drain_all();
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    logic [47:0] sec;
    sent = 0;
    while (sent < n_items) begin
      // bursts fill the queues, then dispatches drain them
      repeat ($urandom_range(1, 40)) begin
        case ($urandom_range(0, 3))
          0: sec = 48'({$urandom, $urandom});
          1: sec = 48'($urandom_range(0, 15));
          2: sec = SECTOR_MAX - 48'($urandom_range(0, 3));
          default: sec = {16'h0, $urandom};
        endcase
        offer_insert($urandom_range(0, 5) == 0, 1'($urandom), sec, TAG_BITS'($urandom));
        sent++;
      end
      repeat ($urandom_range(1, 45)) begin
        offer_dispatch();
        sent++;
      end
    end
    drain_all();
  endtask

  initial begin
    fail_count = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.command = CMD_INSERT;
    in_req.at_head = 1'b0;
    in_req.is_write = 1'b0;
    in_req.start_sector = '0;
    in_req.request_tag = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_full_stores();
    test_backpressure();
    test_random_traffic(1600);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
